[src/tis_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Timestamp interpolation search package
// Shared widths, codes and word types.
// ---------------------------------------------------------------------------
package tis_pkg;
  localparam int TABLE_DEPTH = 4096;
  localparam int TIME_BITS = 62;
  localparam int OFFSET_BITS = 32;
  localparam int INDEX_BITS = $clog2(TABLE_DEPTH);
  localparam int COUNT_BITS = 13;
  localparam int SCALE_BITS = INDEX_BITS + 1;

  localparam logic [1:0] STATUS_FOUND = 2'd0;
  localparam logic [1:0] STATUS_BEFORE = 2'd1;
  localparam logic [1:0] STATUS_AFTER = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef struct packed {
    logic command;
    logic [11:0] entry_index;
    logic [TIME_BITS-1:0] entry_time;
    logic [OFFSET_BITS-1:0] entry_offset;
    logic [TIME_BITS-1:0] search_time;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [11:0] match_index;
    logic [TIME_BITS-1:0] match_time;
    logic [OFFSET_BITS-1:0] match_offset;
  } out_word_t;
endpackage

[src/tis_in_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying load and search words.
// ---------------------------------------------------------------------------
interface tis_in_if import tis_pkg::*; ();
  logic valid;
  logic ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/tis_out_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Output channel
// Valid/ready channel carrying search results.
// ---------------------------------------------------------------------------
interface tis_out_if import tis_pkg::*; ();
  logic valid;
  logic ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/timestamp_interpolation_search_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Timestamp interpolation search unit
// Table of ascending timestamps and offsets with interpolation search.
// ---------------------------------------------------------------------------
// Load words are taken back to back while the unit is idle and no result is
// waiting to be handed over. A search reads the first and last entries, then
// runs probes; each probe is a bit-serial scaling followed by a table read,
// or only the table read when the interval is empty. No new word is taken
// until the search result has been handed over. The probe divider and the
// single read port of the time and offset memories set the search time.
module timestamp_interpolation_search_unit import tis_pkg::*; (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [COUNT_BITS-1:0] cfg_wdata,
  tis_in_if.sink in_ch,
  tis_out_if.source out_ch
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RD0   = 10'b0000000010,
    S_RDL   = 10'b0000000100,
    S_CHK   = 10'b0000001000,
    S_DIV   = 10'b0000010000,
    S_PROBE = 10'b0000100000,
    S_WAIT  = 10'b0001000000,
    S_EVAL  = 10'b0010000000,
    S_FIN   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state;
  logic [COUNT_BITS-1:0] entry_count;
  logic [TIME_BITS-1:0] key, stime, etime;
  logic [INDEX_BITS-1:0] srec, rec, prec, last;
  logic [INDEX_BITS:0] erec;
  logic [1:0] status;
  logic [INDEX_BITS:0] iter;
  logic first;
  logic [TIME_BITS:0] rem;
  logic [TIME_BITS-1:0] dd;
  logic [SCALE_BITS-1:0] q, nn;
  logic [4:0] bitc;
  out_word_t res;
  logic res_valid;

  logic we;
  logic [INDEX_BITS-1:0] waddr, raddr;
  logic [TIME_BITS-1:0] rtime;
  logic [OFFSET_BITS-1:0] roff;

  tis_ram #(.WIDTH(TIME_BITS), .DEPTH(TABLE_DEPTH)) u_time (
    .clk(clk), .we(we), .waddr(waddr), .wdata(in_ch.data.entry_time),
    .raddr(raddr), .rdata(rtime));
  tis_ram #(.WIDTH(OFFSET_BITS), .DEPTH(TABLE_DEPTH)) u_off (
    .clk(clk), .we(we), .waddr(waddr), .wdata(in_ch.data.entry_offset),
    .raddr(raddr), .rdata(roff));

  logic [COUNT_BITS-1:0] n_clamped;
  always_comb begin
    n_clamped = entry_count;
    if (entry_count == '0) n_clamped = COUNT_BITS'(1);
    if (entry_count > COUNT_BITS'(TABLE_DEPTH)) n_clamped = COUNT_BITS'(TABLE_DEPTH);
  end

  assign in_ch.ready = (state == S_IDLE) && !res_valid;
  assign waddr = INDEX_BITS'(in_ch.data.entry_index);
  assign we = in_ch.valid && in_ch.ready && (in_ch.data.command == CMD_LOAD) &&
              (13'(in_ch.data.entry_index) < 13'(TABLE_DEPTH));
  assign out_ch.valid = res_valid;
  assign out_ch.data = res;

  logic [TIME_BITS-1:0] den;
  logic [TIME_BITS:0] r_sh, r_a, r_b;
  logic [SCALE_BITS-1:0] q_a;
  logic [INDEX_BITS:0] probe_sum;
  assign den = etime - stime;
  always_comb begin
    r_sh = {rem[TIME_BITS-1:0], 1'b0};
    q_a = {q[SCALE_BITS-2:0], 1'b0};
    if (rem[TIME_BITS-1] || r_sh >= {1'b0, den}) begin
      r_sh = r_sh - {1'b0, den};
      q_a = q_a + 1'b1;
    end
    r_a = {1'b0, r_sh[TIME_BITS-1:0]};
    r_b = r_a;
    if (nn[SCALE_BITS-1]) begin
      r_b = r_a + {1'b0, dd};
      if (r_b[TIME_BITS] || r_b >= {1'b0, den}) begin
        r_b = r_b - {1'b0, den};
        q_a = q_a + 1'b1;
      end
    end
    probe_sum = {1'b0, srec} + q_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      entry_count <= COUNT_BITS'(1);
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) entry_count <= cfg_wdata;
      if (res_valid && out_ch.ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready && in_ch.data.command == CMD_SEARCH) begin
            key <= in_ch.data.search_time;
            last <= INDEX_BITS'(n_clamped - 1'b1);
            erec <= (INDEX_BITS+1)'(n_clamped);
            raddr <= '0;
            state <= S_RD0;
          end
        end
        S_RD0: begin
          raddr <= last;
          state <= S_RDL;
        end
        S_RDL: begin
          stime <= rtime;
          state <= S_CHK;
        end
        S_CHK: begin
          etime <= rtime;
          srec <= '0;
          rec <= '0;
          iter <= '0;
          first <= 1'b1;
          if (key < stime) begin
            status <= STATUS_BEFORE;
            rec <= '0;
            raddr <= '0;
            state <= S_FIN;
          end else if (key > rtime) begin
            status <= STATUS_AFTER;
            rec <= last;
            raddr <= last;
            state <= S_FIN;
          end else begin
            status <= STATUS_FOUND;
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          prec <= rec;
          if (etime == stime) begin
            raddr <= srec;
            rec <= srec;
            state <= S_WAIT;
          end else begin
            dd <= (key - stime > den) ? den : key - stime;
            nn <= SCALE_BITS'(erec - {1'b0, srec});
            rem <= '0;
            q <= '0;
            bitc <= 5'(SCALE_BITS);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= r_b;
          q <= q_a;
          nn <= {nn[SCALE_BITS-2:0], 1'b0};
          bitc <= bitc - 1'b1;
          if (bitc == 5'd1) begin
            if (probe_sum > {1'b0, last}) begin
              rec <= last;
              raddr <= last;
            end else begin
              rec <= probe_sum[INDEX_BITS-1:0];
              raddr <= probe_sum[INDEX_BITS-1:0];
            end
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          iter <= iter + 1'b1;
          first <= 1'b0;
          if (rtime == key || (!first && prec == rec) ||
              iter == (INDEX_BITS+1)'(TABLE_DEPTH - 1)) begin
            state <= S_FIN;
          end else begin
            if (rtime < key) begin
              srec <= rec;
              stime <= rtime;
            end else begin
              erec <= {1'b0, rec};
              etime <= rtime;
            end
            state <= (prec == rec) ? S_FIN : S_PROBE;
          end
        end
        S_FIN: begin
          state <= S_OUT;
        end
        S_OUT: begin
          res.status <= status;
          res.match_index <= 12'(rec);
          res.match_time <= rtime;
          res.match_offset <= roff;
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[src/tis_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ---------------------------------------------------------------------------
module tis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[verif/timestamp_interpolation_search_unit_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Timestamp interpolation search unit testbench
// Loads ascending timestamp tables of many sizes and shapes, runs searches
// against them under random stalls on both channels, and checks every
// result word against an in-bench model of the interpolation search.
// ---------------------------------------------------------------------------
module timestamp_interpolation_search_unit_tb;
  import tis_pkg::*;

  localparam logic [63:0] TIME_MAX = (64'd1 << TIME_BITS) - 1;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [COUNT_BITS-1:0] cfg_wdata;

  tis_in_if in_ch ();
  tis_out_if out_ch ();

  timestamp_interpolation_search_unit uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  logic [63:0] time_mem [TABLE_DEPTH];
  logic [63:0] offset_mem [TABLE_DEPTH];
  logic [63:0] plan_times [TABLE_DEPTH];
  int entry_count_reg;

  in_word_t word_q [$];
  out_word_t match_q [$];
  int words_queued;
  int words_accepted;
  int send_idle;
  int recv_idle;
  logic hold_go;
  int hold_cnt;
  int fails;
  int status_seen [3];
  int search_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_word_t find_match(logic [63:0] key);
    out_word_t res;
    int n;
    int last;
    int srec;
    int erec;
    int rec;
    int prec;
    logic [63:0] stime;
    logic [63:0] etime;
    logic [63:0] d;
    logic [63:0] t;
    logic [127:0] prod;
    n = entry_count_reg < 1 ? 1 : (entry_count_reg > TABLE_DEPTH ? TABLE_DEPTH : entry_count_reg);
    last = n - 1;
    stime = time_mem[0];
    etime = time_mem[last];
    rec = 0;
    if (key < stime) begin
      res.status = STATUS_BEFORE;
    end else if (key > etime) begin
      res.status = STATUS_AFTER;
      rec = last;
    end else begin
      res.status = STATUS_FOUND;
      srec = 0;
      erec = n;
      for (int it = 0; it < TABLE_DEPTH; it++) begin
        prec = rec;
        if (etime == stime) begin
          rec = srec;
        end else begin
          d = key - stime;
          if (d > etime - stime) d = etime - stime;
          prod = 128'(d) * 128'(erec - srec);
          rec = srec + int'(prod / 128'(etime - stime));
        end
        if (rec > last) rec = last;
        t = time_mem[rec];
        if (t == key) break;
        if (t < key) begin
          srec = rec;
          stime = t;
        end else begin
          erec = rec;
          etime = t;
        end
        if (prec == rec) break;
      end
    end
    res.match_index = rec[11:0];
    res.match_time = time_mem[rec][TIME_BITS-1:0];
    res.match_offset = offset_mem[rec][OFFSET_BITS-1:0];
    return res;
  endfunction

  task automatic take_word(in_word_t w);
    out_word_t m;
    words_accepted++;
    if (w.command == CMD_LOAD) begin
      time_mem[w.entry_index] = 64'(w.entry_time);
      offset_mem[w.entry_index] = 64'(w.entry_offset);
    end else begin
      m = find_match(64'(w.search_time));
      match_q.push_back(m);
      status_seen[m.status]++;
      search_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) take_word(in_ch.data);
      if (!in_ch.valid || in_ch.ready) begin
        if (word_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_ch.data <= word_q.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (match_q.size() == 0) begin
          $error("result word with nothing expected");
          fails++;
        end else begin
          exp_w = match_q.pop_front();
          if (out_ch.data.status !== exp_w.status) begin
            $error("status expected %0d actual %0d", exp_w.status, out_ch.data.status);
            fails++;
          end
          if (out_ch.data.match_index !== exp_w.match_index) begin
            $error("match_index expected %0d actual %0d", exp_w.match_index,
                   out_ch.data.match_index);
            fails++;
          end
          if (out_ch.data.match_time !== exp_w.match_time) begin
            $error("match_time expected %0d actual %0d", exp_w.match_time,
                   out_ch.data.match_time);
            fails++;
          end
          if (out_ch.data.match_offset !== exp_w.match_offset) begin
            $error("match_offset expected %0d actual %0d", exp_w.match_offset,
                   out_ch.data.match_offset);
            fails++;
          end
        end
      end
      if (hold_go) begin
        hold_cnt <= 600;
        out_ch.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  function automatic logic [63:0] rand_time();
    return {$urandom, $urandom} & TIME_MAX;
  endfunction

  task automatic queue_word(in_word_t w);
    word_q.push_back(w);
    words_queued++;
  endtask

  task automatic queue_load(int idx, logic [63:0] t, logic [31:0] off);
    in_word_t w;
    w = '0;
    w.command = CMD_LOAD;
    w.entry_index = idx[11:0];
    w.entry_time = t[TIME_BITS-1:0];
    w.entry_offset = off;
    w.search_time = rand_time();
    queue_word(w);
  endtask

  task automatic queue_search(logic [63:0] key);
    in_word_t w;
    w = '0;
    w.command = CMD_SEARCH;
    w.entry_index = 12'($urandom);
    w.entry_time = rand_time();
    w.entry_offset = $urandom;
    w.search_time = key[TIME_BITS-1:0];
    queue_word(w);
  endtask

  task automatic wait_idle();
    while (words_accepted != words_queued || match_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_count(int value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value[COUNT_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    entry_count_reg = value;
  endtask

  // shape 0: uniform random steps, 1: exponential growth, 2: many repeats
  task automatic load_table(int n, int shape, bit reverse);
    logic [63:0] step;
    int k;
    plan_times[0] = (shape == 1 || $urandom_range(3) == 0) ? 64'd0 : rand_time() >> 4;
    step = (TIME_MAX - plan_times[0]) / 64'(n);
    for (int i = 1; i < n; i++) begin
      case (shape)
        1: begin
          plan_times[i] = plan_times[i-1] + (64'd1 << (i < 50 ? i : 50)) + 64'($urandom_range(7));
        end
        2: begin
          plan_times[i] = plan_times[i-1] + ($urandom_range(2) == 0 ? 64'($urandom_range(3)) : 64'd0);
        end
        default: begin
          plan_times[i] = plan_times[i-1] + rand_time() % (step + 1);
        end
      endcase
    end
    for (int i = 0; i < n; i++) begin
      k = reverse ? n - 1 - i : i;
      queue_load(k, plan_times[k], $urandom);
    end
    if (n < TABLE_DEPTH) queue_load($urandom_range(TABLE_DEPTH - 1, n), rand_time(), $urandom);
  endtask

  task automatic random_searches(int n, int count);
    logic [63:0] lo_t;
    logic [63:0] hi_t;
    int a;
    for (int i = 0; i < count; i++) begin
      a = $urandom_range(n - 1);
      lo_t = plan_times[a];
      hi_t = plan_times[a < n - 1 ? a + 1 : a];
      case ($urandom_range(9))
        0, 1, 2: queue_search(lo_t);
        3, 4, 5: queue_search(lo_t + (hi_t - lo_t == 0 ? 64'd0 : rand_time() % (hi_t - lo_t)));
        6: queue_search(plan_times[0] == 0 ? 64'd0 : rand_time() % plan_times[0]);
        7: queue_search(plan_times[n-1] == TIME_MAX ? TIME_MAX :
                        plan_times[n-1] + 1 + rand_time() % (TIME_MAX - plan_times[n-1]));
        default: queue_search(rand_time());
      endcase
    end
  endtask

  task automatic full_table_searches();
    queue_search(plan_times[0]);
    queue_search(plan_times[TABLE_DEPTH-1]);
    queue_search(plan_times[0] - 1);
    queue_search(64'd0);
    queue_search(TIME_MAX);
  endtask

  task automatic run_phase(int phase, int n, int shape, int searches);
    wait_idle();
    send_idle <= phase < 5 ? 36 : (phase < 10 ? 78 : 0);
    recv_idle <= phase < 5 ? 78 : (phase < 10 ? 36 : 0);
    write_count(n);
    load_table(n, shape, phase[0]);
    random_searches(n, searches);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    hold_go = 1'b0;
    send_idle = 36;
    recv_idle = 78;
    fails = 0;
    search_cnt = 0;
    words_queued = 0;
    words_accepted = 0;
    status_seen = '{0, 0, 0};
    entry_count_reg = 1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      time_mem[i] = 0;
      offset_mem[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Two entries spanning the whole time range, extreme offsets.
    write_count(2);
    plan_times[0] = 64'd0;
    plan_times[1] = TIME_MAX;
    queue_load(0, 64'd0, 32'h0);
    queue_load(1, TIME_MAX, 32'hFFFF_FFFF);
    queue_search(64'd0);
    queue_search(TIME_MAX);
    queue_search(64'd1);
    queue_search(TIME_MAX - 1);
    queue_search(TIME_MAX >> 1);

    // Equal times force the empty interval case.
    write_count(3);
    plan_times[0] = 5;
    plan_times[1] = 5;
    plan_times[2] = 5;
    for (int i = 0; i < 3; i++) queue_load(i, 64'd5, $urandom);
    queue_search(64'd4);
    queue_search(64'd5);
    queue_search(64'd6);
    queue_search(64'd0);
    queue_search(TIME_MAX);

    run_phase(0, 1, 0, 30);
    run_phase(1, 5, 2, 60);
    run_phase(2, 8, 0, 60);
    run_phase(3, 16, 1, 80);
    run_phase(4, 33, 0, 80);

    wait_idle();
    send_idle <= 78;
    recv_idle <= 36;
    write_count(64);
    load_table(64, 0, 1'b0);
    wait_idle();
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    random_searches(64, 80);

    run_phase(6, 100, 0, 50);
    run_phase(7, 200, 2, 50);
    run_phase(8, 40, 1, 50);
    run_phase(9, 129, 0, 50);

    // A full table where only the two end entries are ever read: a key equal
    // to the last time scales to one past the end and is pulled back.
    wait_idle();
    send_idle <= 0;
    recv_idle <= 0;
    write_count(TABLE_DEPTH);
    plan_times[0] = 64'd1000;
    plan_times[TABLE_DEPTH-1] = TIME_MAX - 64'd1000;
    queue_load(0, plan_times[0], $urandom);
    queue_load(TABLE_DEPTH - 1, plan_times[TABLE_DEPTH-1], $urandom);
    full_table_searches();

    // Counts above the table depth act as the full table.
    write_count((1 << COUNT_BITS) - 1);
    full_table_searches();

    // A count of zero acts as one entry.
    write_count(0);
    queue_search(plan_times[0]);
    queue_search(plan_times[0] + 1);
    if (plan_times[0] != 0) queue_search(plan_times[0] - 1);
    write_count(1);
    queue_search(plan_times[0]);
    queue_search(TIME_MAX);
    run_phase(11, 12, 0, 60);

    wait_idle();
    repeat (200) @(posedge clk);
    $display("Ran %0d searches over tables of 1 to %0d entries, including count extremes.",
             search_cnt, TABLE_DEPTH);
    $display("Status mix: %0d found, %0d before start, %0d after end.",
             status_seen[0], status_seen[1], status_seen[2]);
    if (fails == 0) begin
      $display("timestamp_interpolation_search_unit verification clean");
    end else begin
      $display("timestamp_interpolation_search_unit verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timestamp_interpolation_search_unit verification failed");
    $finish;
  end
endmodule
